### hw/rtl/fit_allocator_table_top_defines.svh
// ---------------------------------------------------------------------------
// fit_allocator_table_top_defines.svh
// Assertion macros for the allocation table. Empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef FIT_ALLOCATOR_TABLE_TOP_DEFINES_SVH
`define FIT_ALLOCATOR_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define FAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define FAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FAT_ASSERT(lbl, prop, msg)
`define FAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/fat_pkg.sv
// ---------------------------------------------------------------------------
// fat_pkg
// Shared types and codes for the address-ordered allocation table.
// ---------------------------------------------------------------------------
package fat_pkg;

  localparam int unsigned ADDR_BITS      = 20;
  localparam int unsigned ID_BITS        = 16;
  localparam int unsigned MAX_BLOCKS_DEF = 16;

  localparam logic [1:0] CMD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_BEST   = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;
  localparam logic [1:0] CMD_DEFRAG = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXCEEDS  = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOHOLE   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [ID_BITS-1:0]   block_id;
    logic [ADDR_BITS-1:0] req_units;
  } fat_in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] block_start;
    logic [ADDR_BITS-1:0] block_end;
    logic [ADDR_BITS-1:0] free_space;
  } fat_out_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   blk_id;
    logic [ADDR_BITS-1:0] blk_start;
    logic [ADDR_BITS-1:0] blk_end;
  } fat_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic ins;
    logic del;
    logic fin;
    logic pvld;    // table read data valid this cycle
    logic rd_en;
  } fat_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic go_ins;
    logic go_del;
  } fat_sts_t;

endpackage

### hw/rtl/fit_allocator_table_top.sv
// ---------------------------------------------------------------------------
// fit_allocator_table_top
// Address-ordered block allocator: first-fit, best-fit, free by id, defragment.
//
//   channel  direction  handshake                 payload
//   command  in         start / busy              item_i  (fat_in_t)
//   result   out        done_o strobe, one cycle  result_o (fat_out_t)
//   config   in         cfg_valid_i / cfg_ready_o cfg_data_i (memory size)
//
// One command at a time. The scan reads every live entry through the registered
// table read port, then a decision cycle; an insert at slot k moves each entry
// from slot k on up a slot, a free of slot p moves each entry behind p down a
// slot; then the commit cycle, with the result strobe in the next.
// Reset leaves memory size and free space at zero; a memory size write clears
// the table at once, no clearing pass. Results cannot be held off.
// ---------------------------------------------------------------------------
module fit_allocator_table_top #(
  parameter int unsigned MAX_BLOCKS = fat_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  fat_pkg::fat_in_t              item_i,
  output logic                          done_o,
  output fat_pkg::fat_out_t             result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fat_pkg::ADDR_BITS-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  fat_pkg::fat_ctl_t ctl;
  fat_pkg::fat_sts_t sts;
  logic [AW-1:0]     rd_addr, pidx, pos;
  logic [CW-1:0]     count, pick;

  assign cfg_ready_o = !busy;

  fat_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .count_i   (count),
    .pick_i    (pick),
    .pos_i     (pos),
    .sts_i     (sts),
    .ctl_o     (ctl),
    .rd_addr_o (rd_addr),
    .pidx_o    (pidx),
    .busy_o    (busy)
  );

  fat_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ctl_i      (ctl),
    .rd_addr_i  (rd_addr),
    .pidx_i     (pidx),
    .sts_o      (sts),
    .count_o    (count),
    .pick_o     (pick),
    .pos_o      (pos),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

### hw/rtl/fat_dp.sv
// ---------------------------------------------------------------------------
// fat_dp
// Datapath: entry table memory, hole search, id match, shifts and counters.
// ---------------------------------------------------------------------------
`include "fit_allocator_table_top_defines.svh"

module fat_dp #(
  parameter int unsigned MAX_BLOCKS = fat_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned AW = $clog2(MAX_BLOCKS),
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fat_pkg::fat_in_t               item_i,
  input  logic                           cfg_we_i,
  input  logic [fat_pkg::ADDR_BITS-1:0]  cfg_data_i,
  input  fat_pkg::fat_ctl_t              ctl_i,
  input  logic [AW-1:0]                  rd_addr_i,
  input  logic [AW-1:0]                  pidx_i,
  output fat_pkg::fat_sts_t              sts_o,
  output logic [CW-1:0]                  count_o,
  output logic [CW-1:0]                  pick_o,
  output logic [AW-1:0]                  pos_o,
  output logic                           done_o,
  output fat_pkg::fat_out_t              result_o
);

  localparam int unsigned A = fat_pkg::ADDR_BITS;

  fat_pkg::fat_entry_t mem_q [MAX_BLOCKS];
  fat_pkg::fat_entry_t rd_q;

  logic [1:0]               cmd_q;
  logic [fat_pkg::ID_BITS-1:0] id_q;
  logic [A-1:0]             size_q;
  logic [A-1:0]             mem_size_q, free_q, free_d;
  logic [CW-1:0]            count_q;
  logic [A-1:0]             prev_q, best_q, lo_q;
  logic [CW-1:0]            pick_q;
  logic [AW-1:0]            pos_q;
  logic [A-1:0]             fstart_q, fend_q;
  logic [2:0]               st_q;
  logic [A-1:0]             rs_q, re_q;
  logic                     found_q, dup_q, hit_q, done_q;
  fat_pkg::fat_out_t        out_q;

  logic                     is_alloc, is_best, is_free, is_defrag;
  logic [A-1:0]             hs_e, len_e, hs_l, fin_lo;
  logic                     cand_e, cand_l, id_eq, empty, fin_found;
  logic [CW-1:0]            fin_pick;
  logic [2:0]               st_c;
  logic [A-1:0]             rs_c, re_c;
  logic                     we;
  logic [AW-1:0]            waddr;
  fat_pkg::fat_entry_t      wdata;

  assign is_alloc  = cmd_q inside {fat_pkg::CMD_FIRST, fat_pkg::CMD_BEST};
  assign is_best   = (cmd_q == fat_pkg::CMD_BEST);
  assign is_free   = (cmd_q == fat_pkg::CMD_FREE);
  assign is_defrag = (cmd_q == fat_pkg::CMD_DEFRAG);

  // hole in front of the entry just read; a negative gap counts as empty
  assign hs_e   = (rd_q.blk_start > prev_q) ? rd_q.blk_start - prev_q : '0;
  assign len_e  = rd_q.blk_end - rd_q.blk_start;
  assign cand_e = (size_q <= hs_e) && (!found_q || (is_best && (hs_e < best_q)));
  assign id_eq  = (rd_q.blk_id == id_q);

  // trailing hole, up to the end of memory
  assign hs_l      = (mem_size_q > prev_q) ? mem_size_q - prev_q : '0;
  assign cand_l    = (size_q <= hs_l) && (!found_q || (is_best && (hs_l < best_q)));
  assign empty     = (count_q == '0);
  assign fin_found = empty || found_q || cand_l;
  assign fin_pick  = empty ? '0 : (cand_l ? count_q : pick_q);
  assign fin_lo    = empty ? '0 : (cand_l ? prev_q : lo_q);

  always_comb begin
    st_c = fat_pkg::ST_OK;
    rs_c = '0;
    re_c = '0;
    case (cmd_q)
      fat_pkg::CMD_FIRST, fat_pkg::CMD_BEST: begin
        if (size_q > free_q) begin
          st_c = fat_pkg::ST_EXCEEDS;
        end else if (dup_q) begin
          st_c = fat_pkg::ST_DUP;
        end else if (count_q >= CW'(MAX_BLOCKS)) begin
          st_c = fat_pkg::ST_FULL;
        end else if (!fin_found) begin
          st_c = fat_pkg::ST_NOHOLE;
        end else begin
          rs_c = fin_lo;
          re_c = fin_lo + size_q;
        end
      end
      fat_pkg::CMD_FREE: begin
        if (hit_q) begin
          rs_c = fstart_q;
          re_c = fend_q;
        end else begin
          st_c = fat_pkg::ST_NOTFOUND;
        end
      end
      default: st_c = fat_pkg::ST_OK;
    endcase
  end

  assign sts_o.go_ins = ctl_i.decide && is_alloc && (st_c == fat_pkg::ST_OK);
  assign sts_o.go_del = ctl_i.decide && is_free && (st_c == fat_pkg::ST_OK);

  always_comb begin
    free_d = free_q;
    if (st_q == fat_pkg::ST_OK) begin
      if (is_alloc) begin
        free_d = free_q - size_q;
      end else if (is_free) begin
        free_d = free_q + (re_q - rs_q);
      end
    end
  end

  // single table write port
  always_comb begin
    we    = 1'b0;
    waddr = pidx_i;
    wdata = rd_q;
    if (ctl_i.scan && ctl_i.pvld && is_defrag) begin
      we    = 1'b1;
      wdata = '{blk_id: rd_q.blk_id, blk_start: prev_q, blk_end: prev_q + len_e};
    end else if (ctl_i.ins && ctl_i.pvld) begin
      we    = 1'b1;
      waddr = pidx_i + AW'(1);
    end else if (ctl_i.del && ctl_i.pvld) begin
      we    = 1'b1;
      waddr = pidx_i - AW'(1);
    end else if (ctl_i.fin && is_alloc && (st_q == fat_pkg::ST_OK)) begin
      we    = 1'b1;
      waddr = pick_q[AW-1:0];
      wdata = '{blk_id: id_q, blk_start: rs_q, blk_end: re_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= '0;
      free_q     <= '0;
      count_q    <= '0;
      found_q    <= 1'b0;
      dup_q      <= 1'b0;
      hit_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= ctl_i.fin;
      if (cfg_we_i) begin
        mem_size_q <= cfg_data_i;
        free_q     <= cfg_data_i;
        count_q    <= '0;
      end
      if (ctl_i.load) begin
        found_q <= 1'b0;
        dup_q   <= 1'b0;
        hit_q   <= 1'b0;
      end
      if (ctl_i.scan && ctl_i.pvld) begin
        if (cand_e) found_q <= 1'b1;
        if (id_eq) begin
          dup_q <= 1'b1;
          hit_q <= 1'b1;
        end
      end
      if (ctl_i.fin) begin
        free_q <= free_d;
        if (st_q == fat_pkg::ST_OK) begin
          if (is_alloc) begin
            count_q <= count_q + CW'(1);
          end else if (is_free) begin
            count_q <= count_q - CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= item_i.cmd;
      id_q   <= item_i.block_id;
      size_q <= item_i.req_units;
      prev_q <= '0;
    end
    if (ctl_i.scan && ctl_i.pvld) begin
      prev_q <= is_defrag ? prev_q + len_e : rd_q.blk_end;
      if (cand_e) begin
        best_q <= hs_e;
        lo_q   <= prev_q;
        pick_q <= CW'(pidx_i);
      end
      if (id_eq && !hit_q) begin
        pos_q    <= pidx_i;
        fstart_q <= rd_q.blk_start;
        fend_q   <= rd_q.blk_end;
      end
    end
    if (ctl_i.decide) begin
      st_q   <= st_c;
      pick_q <= fin_pick;
      rs_q   <= rs_c;
      re_q   <= re_c;
    end
    if (ctl_i.fin) begin
      out_q <= '{status: st_q, block_start: rs_q, block_end: re_q, free_space: free_d};
    end
  end

  assign count_o  = count_q;
  assign pick_o   = pick_q;
  assign pos_o    = pos_q;
  assign done_o   = done_q;
  assign result_o = out_q;

  `FAT_ASSERT(a_count_max, count_q <= CW'(MAX_BLOCKS), "entry count beyond table depth")
  `FAT_ASSERT(a_done_after_fin, done_q |-> $past(ctl_i.fin), "result without a finish cycle")
  `FAT_ASSERT(a_full_count,
    (ctl_i.fin && (st_q == fat_pkg::ST_FULL)) |-> (count_q == CW'(MAX_BLOCKS)),
    "table full reported below depth")

endmodule

### hw/rtl/fat_ctrl.sv
// ---------------------------------------------------------------------------
// fat_ctrl
// Sequencer: table scan, decision, insert/remove shifts, commit.
// ---------------------------------------------------------------------------
`include "fit_allocator_table_top_defines.svh"

module fat_ctrl #(
  parameter int unsigned MAX_BLOCKS = fat_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned AW = $clog2(MAX_BLOCKS),
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CW-1:0]     count_i,
  input  logic [CW-1:0]     pick_i,
  input  logic [AW-1:0]     pos_i,
  input  fat_pkg::fat_sts_t sts_i,
  output fat_pkg::fat_ctl_t ctl_o,
  output logic [AW-1:0]     rd_addr_o,
  output logic [AW-1:0]     pidx_o,
  output logic              busy_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_INS    = 3'd3;
  localparam logic [2:0] S_DEL    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d, idx_m1;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          pvld_q, pvld_d;
  logic          rd_en;

  assign idx_m1 = idx_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pidx_d    = pidx_q;
    pvld_d    = 1'b0;
    rd_en     = 1'b0;
    rd_addr_o = idx_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        if (idx_q < count_i) begin
          rd_en  = 1'b1;
          pvld_d = 1'b1;
          pidx_d = idx_q[AW-1:0];
          idx_d  = idx_q + CW'(1);
        end else if (!pvld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.go_ins) begin
          state_d = S_INS;
          idx_d   = count_i;
        end else if (sts_i.go_del) begin
          state_d = S_DEL;
          idx_d   = CW'(pos_i) + CW'(1);
        end else begin
          state_d = S_FIN;
        end
      end
      S_INS: begin
        // walk down from the last entry, each one moves up a slot
        if (idx_q > pick_i) begin
          rd_en     = 1'b1;
          rd_addr_o = idx_m1[AW-1:0];
          pvld_d    = 1'b1;
          pidx_d    = idx_m1[AW-1:0];
          idx_d     = idx_m1;
        end else if (!pvld_q) begin
          state_d = S_FIN;
        end
      end
      S_DEL: begin
        if (idx_q < count_i) begin
          rd_en  = 1'b1;
          pvld_d = 1'b1;
          pidx_d = idx_q[AW-1:0];
          idx_d  = idx_q + CW'(1);
        end else if (!pvld_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pidx_q  <= '0;
      pvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pidx_q  <= pidx_d;
      pvld_q  <= pvld_d;
    end
  end

  assign ctl_o.load   = (state_q == S_IDLE) && start_i;
  assign ctl_o.scan   = (state_q == S_SCAN);
  assign ctl_o.decide = (state_q == S_DECIDE);
  assign ctl_o.ins    = (state_q == S_INS);
  assign ctl_o.del    = (state_q == S_DEL);
  assign ctl_o.fin    = (state_q == S_FIN);
  assign ctl_o.pvld   = pvld_q;
  assign ctl_o.rd_en  = rd_en;
  assign pidx_o       = pidx_q;
  assign busy_o       = (state_q != S_IDLE);

  `FAT_ASSERT_ALWAYS(a_idle_no_data, (state_q == S_IDLE) |-> !pvld_q,
    "read data pending while idle")
  `FAT_ASSERT(a_start_scan, ((state_q == S_IDLE) && start_i) |=> (state_q == S_SCAN),
    "accepted command did not start a scan")
  `FAT_ASSERT(a_rd_in_table, rd_en |-> (CW'(rd_addr_o) < count_i),
    "table read beyond live entries")

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Allocation table testbench
// Drives first-fit, best-fit, free and defragment commands into the table
// and checks every result against an in-bench model of the block list.
// Directed cases come first, then random traffic at several memory sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import fat_pkg::*;

  localparam int MAX_ENTRIES = MAX_BLOCKS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  fat_in_t              cmd_item  = '0;
  logic                 done;
  fat_out_t             result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [ADDR_BITS-1:0] cfg_data  = '0;

  // block list model
  logic [ID_BITS-1:0]   tbl_id   [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] tbl_lo   [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] tbl_hi   [MAX_ENTRIES];
  int                   tbl_count  = 0;
  logic [ADDR_BITS-1:0] units_free = '0;
  logic [ADDR_BITS-1:0] mem_units  = '0;

  fat_out_t awaited_results[$];
  fat_out_t want;
  int       mismatches  = 0;
  int       items_sent  = 0;
  int       results_seen = 0;
  int       sizes_set   = 0;
  int       status_seen [8];
  int       stall_cycles = 0;
  bit       idle_en     = 1'b1;

  fit_allocator_table_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (cmd_item),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic logic [ADDR_BITS-1:0] hole_base(int k);
    if (k == 0) return '0;
    return tbl_hi[k-1];
  endfunction

  // gap before entry k, or after the last entry; a reversed gap is empty
  function automatic logic [ADDR_BITS-1:0] hole_len(int k);
    logic [ADDR_BITS-1:0] lo, hi;
    lo = hole_base(k);
    hi = (k < tbl_count) ? tbl_lo[k] : mem_units;
    return (hi > lo) ? hi - lo : '0;
  endfunction

  function automatic int find_entry(logic [ID_BITS-1:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void load_mem_size(logic [ADDR_BITS-1:0] v);
    mem_units  = v;
    units_free = v;
    tbl_count  = 0;
  endfunction

  function automatic fat_out_t run_table_cmd(fat_in_t it);
    fat_out_t             res;
    int                   pos, pick;
    bit                   found;
    logic [ADDR_BITS-1:0] best, hs, len, prev;
    res        = '0;
    res.status = ST_OK;
    case (it.cmd)
      CMD_FIRST, CMD_BEST: begin
        if (it.req_units > units_free) begin
          res.status = ST_EXCEEDS;
        end else if (find_entry(it.block_id) >= 0) begin
          res.status = ST_DUP;
        end else if (tbl_count >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          found = (tbl_count == 0);
          pick  = 0;
          best  = '0;
          if (!found) begin
            for (int k = 0; k <= tbl_count; k++) begin
              hs = hole_len(k);
              if (it.req_units <= hs && (!found || hs < best)) begin
                found = 1'b1;
                pick  = k;
                best  = hs;
                if (it.cmd == CMD_FIRST) break;
              end
            end
          end
          if (!found) begin
            res.status = ST_NOHOLE;
          end else begin
            res.block_start = hole_base(pick);
            res.block_end   = res.block_start + it.req_units;
            for (int i = tbl_count; i > pick; i--) begin
              tbl_id[i] = tbl_id[i-1];
              tbl_lo[i] = tbl_lo[i-1];
              tbl_hi[i] = tbl_hi[i-1];
            end
            tbl_id[pick] = it.block_id;
            tbl_lo[pick] = res.block_start;
            tbl_hi[pick] = res.block_end;
            tbl_count++;
            units_free = units_free - it.req_units;
          end
        end
      end
      CMD_FREE: begin
        pos = find_entry(it.block_id);
        if (pos < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.block_start = tbl_lo[pos];
          res.block_end   = tbl_hi[pos];
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_id[i] = tbl_id[i+1];
            tbl_lo[i] = tbl_lo[i+1];
            tbl_hi[i] = tbl_hi[i+1];
          end
          tbl_count--;
          units_free = units_free + (res.block_end - res.block_start);
        end
      end
      default: begin
        prev = '0;
        for (int i = 0; i < tbl_count; i++) begin
          len       = tbl_hi[i] - tbl_lo[i];
          tbl_lo[i] = prev;
          tbl_hi[i] = prev + len;
          prev      = tbl_hi[i];
        end
      end
    endcase
    res.free_space = units_free;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic fat_in_t make_item(logic [1:0] c, logic [ID_BITS-1:0] id,
                                        logic [ADDR_BITS-1:0] sz);
    fat_in_t it;
    it.cmd       = c;
    it.block_id  = id;
    it.req_units = sz;
    return it;
  endfunction

  function automatic logic [ID_BITS-1:0] pick_id(int live_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < live_pct && tbl_count > 0) return tbl_id[$urandom_range(0, tbl_count - 1)];
    if (r < 90) return ID_BITS'($urandom_range(0, 47));
    return ID_BITS'($urandom);
  endfunction

  function automatic logic [ADDR_BITS-1:0] alloc_size();
    int r;
    int span;
    r    = $urandom_range(0, 99);
    span = (int'(mem_units) < 10) ? 1 : int'(mem_units) / 10;
    if (r < 5) return '0;
    if (r < 15) begin
      if (units_free == ADDR_MAX) return ADDR_MAX;
      return ADDR_BITS'($urandom_range(int'(units_free) + 1, int'(ADDR_MAX)));
    end
    if (r < 20) return ADDR_BITS'($urandom);
    return ADDR_BITS'($urandom_range(1, span));
  endfunction

  // start stays high across back-to-back transfers
  task automatic send_cmd(input fat_in_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start    <= 1'b1;
    cmd_item <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    awaited_results.push_back(run_table_cmd(it));
    items_sent++;
  endtask

  task automatic finish_outstanding();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_memory_size(input logic [ADDR_BITS-1:0] v);
    finish_outstanding();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    load_mem_size(v);
    sizes_set++;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void compare_field(string what, logic [ADDR_BITS-1:0] exp_v,
                                        logic [ADDR_BITS-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no command outstanding, expected none, got %h",
                 $time, result);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", ADDR_BITS'(want.status), ADDR_BITS'(result.status));
        compare_field("block_start", want.block_start, result.block_start);
        compare_field("block_end", want.block_end, result.block_end);
        compare_field("free_space", want.free_space, result.free_space);
        status_seen[want.status]++;
        results_seen++;
      end
    end
  end

  // no transfer of any kind for too long means the block has hung
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("[fit_allocator_table_top] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset leaves a zero-sized memory: only empty blocks fit
  task automatic test_zero_memory();
    send_cmd(make_item(CMD_FIRST, 16'h0000, 20'd0));
    send_cmd(make_item(CMD_BEST, 16'hFFFF, 20'd0));
    send_cmd(make_item(CMD_FIRST, 16'h0001, 20'd1));
    send_cmd(make_item(CMD_FREE, 16'h0000, 20'd0));
    send_cmd(make_item(CMD_FREE, 16'h1234, 20'd0));
    send_cmd(make_item(CMD_DEFRAG, 16'h0000, 20'd0));
  endtask

  // fill, punch two equal holes, then check refusals, tie-break and packing
  task automatic test_fragmentation();
    set_memory_size(20'd100);
    send_cmd(make_item(CMD_FIRST, 16'd1, 20'd30));
    send_cmd(make_item(CMD_FIRST, 16'd2, 20'd20));
    send_cmd(make_item(CMD_FIRST, 16'd3, 20'd30));
    send_cmd(make_item(CMD_FIRST, 16'd4, 20'd20));
    send_cmd(make_item(CMD_FIRST, 16'd5, 20'd1));
    send_cmd(make_item(CMD_FIRST, 16'd2, 20'd0));
    send_cmd(make_item(CMD_FREE, 16'd2, 20'd0));
    send_cmd(make_item(CMD_FREE, 16'd4, 20'd0));
    send_cmd(make_item(CMD_FIRST, 16'd5, 20'd30));
    send_cmd(make_item(CMD_BEST, 16'd6, 20'd10));
    send_cmd(make_item(CMD_FIRST, 16'd7, 20'd15));
    send_cmd(make_item(CMD_DEFRAG, 16'd0, 20'd0));
    send_cmd(make_item(CMD_FIRST, 16'd8, 20'd15));
  endtask

  task automatic test_full_range();
    set_memory_size(ADDR_MAX);
    send_cmd(make_item(CMD_FIRST, 16'hFFFF, ADDR_MAX));
    send_cmd(make_item(CMD_FREE, 16'hFFFF, 20'd0));
    send_cmd(make_item(CMD_BEST, 16'hAAAA, ADDR_MAX));
    send_cmd(make_item(CMD_FIRST, 16'h5555, 20'd0));
  endtask

  task automatic test_fill_table();
    set_memory_size(20'd256);
    for (int i = 0; i < MAX_ENTRIES; i++)
      send_cmd(make_item($urandom_range(0, 1) ? CMD_BEST : CMD_FIRST,
                         ID_BITS'(16'h0100 + i), ADDR_BITS'($urandom_range(0, 16))));
    send_cmd(make_item(CMD_FIRST, 16'h0200, 20'd1));
    send_cmd(make_item(CMD_BEST, 16'h0105, 20'd1));
    send_cmd(make_item(CMD_FIRST, 16'h0201, 20'd300));
    send_cmd(make_item(CMD_FREE, 16'h0107, 20'd0));
    send_cmd(make_item(CMD_BEST, 16'h0200, ADDR_BITS'($urandom_range(0, 16))));
    send_cmd(make_item(CMD_DEFRAG, 16'h0000, 20'd0));
    send_cmd(make_item(CMD_FREE, pick_id(100), 20'd0));
  endtask

  task automatic test_random_traffic(input logic [ADDR_BITS-1:0] mem, input int n,
                                     input bit with_gaps);
    int r;
    idle_en = with_gaps;
    set_memory_size(mem);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        send_cmd(make_item(CMD_FIRST, pick_id(10), alloc_size()));
      else if (r < 60)
        send_cmd(make_item(CMD_BEST, pick_id(10), alloc_size()));
      else if (r < 92)
        send_cmd(make_item(CMD_FREE, pick_id(75), ADDR_BITS'($urandom)));
      else
        send_cmd(make_item(CMD_DEFRAG, ID_BITS'($urandom), ADDR_BITS'($urandom)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_memory();
    test_fragmentation();
    test_full_range();
    test_fill_table();
    test_random_traffic(20'd200, 60, 1'b1);
    test_random_traffic(20'd0, 20, 1'b1);
    test_random_traffic(ADDR_BITS'($urandom_range(1, int'(ADDR_MAX))), 60, 1'b1);
    test_random_traffic(ADDR_MAX, 60, 1'b1);
    test_random_traffic(ADDR_BITS'($urandom_range(16, 512)), 80, 1'b1);
    test_random_traffic(20'd1000, 80, 1'b0);

    finish_outstanding();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands across %0d memory sizes, %0d results checked.",
             items_sent, sizes_set, results_seen);
    $display("Outcomes: ok %0d, too large %0d, duplicate %0d, no hole %0d, absent %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_EXCEEDS], status_seen[ST_DUP],
             status_seen[ST_NOHOLE], status_seen[ST_NOTFOUND], status_seen[ST_FULL]);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[fit_allocator_table_top] OK");
    end else begin
      $display("[fit_allocator_table_top] ERROR");
    end
    $finish;
  end

endmodule

### fit_allocator_table_top.f
+incdir+hw/rtl
hw/rtl/fat_pkg.sv
hw/rtl/fat_dp.sv
hw/rtl/fat_ctrl.sv
hw/rtl/fit_allocator_table_top.sv
tb/testbench.sv
